FILE: src/fenwick_range_add_point_query_assert.svh
// Assertion macros shared by the Fenwick range-add block.
`ifndef FENWICK_RANGE_ADD_POINT_QUERY_ASSERT_SVH
`define FENWICK_RANGE_ADD_POINT_QUERY_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FRPQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define FRPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/frpq_pkg.sv
// Shared types and constants of the Fenwick range-add, point-query block.
package frpq_pkg;

  localparam int unsigned DEF_MAX_POSITIONS = 1024;

  localparam int unsigned POS_W    = 11;
  localparam int unsigned AMOUNT_W = 32;
  localparam int unsigned VALUE_W  = 64;

  // Input word layout, lowest bit first.
  localparam int unsigned LOW_LSB   = 0;
  localparam int unsigned HIGH_LSB  = LOW_LSB + POS_W;
  localparam int unsigned AMT_LSB   = HIGH_LSB + POS_W;
  localparam int unsigned QPOS_LSB  = AMT_LSB + AMOUNT_W;
  localparam int unsigned IN_BITS   = QPOS_LSB + POS_W;
  localparam int unsigned IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

  localparam logic [POS_W-1:0] SIZE_RESET = POS_W'(1024);

  typedef enum logic {
    REQ_ADD   = 1'b0,
    REQ_QUERY = 1'b1
  } req_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UP_CHK,
    ST_UP_WR,
    ST_DN_CHK,
    ST_DN_ACC
  } state_e;

endpackage

FILE: src/fenwick_range_add_point_query.sv
// Fenwick tree with range add and point query, top level.
//
// Items arrive on the s_axis word channel. tuser selects the request: a range
// add puts the signed amount on positions range_low..range_high, a point query
// returns the current value of one position as a 64-bit word on m_axis. The user
// must write the tree size register on the cfg channel only while the block is
// idle; the block itself does not enforce this.
// One shared 64-bit add/subtract unit and one index step unit do all the work
// under a small sequencer; the tree sits in a memory with registered read.
// A range add reads, then writes, each tree entry it touches, with one closing
// check at the end of each walk; the second walk, at range_high+1, runs only
// when that position is within the size. A point query visits each set bit of
// the position, adds each entry within the size, then hands the sum over once
// the output register is free. The block is not ready while an item is being
// worked on and passes through its idle state between items.
//
// After reset the memory is swept to zero, one entry a cycle, before the first
// item is taken. A finished query waits in an output register, so a new item is
// accepted while the receiver stalls; a second query only completes once that
// register has been taken.
`include "fenwick_range_add_point_query_assert.svh"

module fenwick_range_add_point_query
  import frpq_pkg::*;
#(
  parameter int unsigned MAX_POSITIONS = DEF_MAX_POSITIONS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // tdata, lowest bit first: range_low[10:0], range_high[21:11],
  // amount[53:22], query_position[64:54], zero fill[71:65].
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,
  // tuser: req_type[0].
  input  logic                 s_axis_tuser,
  // tdata: point_value[63:0].
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [VALUE_W-1:0]   m_axis_tdata,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [POS_W-1:0]     cfg_data_i
);

  localparam int unsigned AW    = $clog2(MAX_POSITIONS);
  localparam int unsigned IW_N  = $clog2(MAX_POSITIONS + 1) + 1;
  localparam int unsigned IW    = (IW_N > POS_W + 1) ? IW_N : POS_W + 1;
  localparam logic [AW-1:0] CLR_LAST = AW'(MAX_POSITIONS - 1);
  localparam logic [IW-1:0] MAX_IDX  = IW'(MAX_POSITIONS);

  state_e             state_q, state_d;
  logic [POS_W-1:0]   size_q;
  logic [AW-1:0]      clr_q, clr_d;
  logic [IW-1:0]      idx_q, idx_d;
  logic [IW-1:0]      hi_q, hi_d;
  logic               second_q, second_d;
  logic [VALUE_W-1:0] delta_q, delta_d;
  logic [VALUE_W-1:0] acc_q, acc_d;
  logic               out_valid_q, out_valid_d;
  logic [VALUE_W-1:0] out_data_q, out_data_d;

  logic [IW-1:0]      size_ext;
  logic [IW-1:0]      n_eff;
  logic [IW-1:0]      low_bit;
  logic [IW-1:0]      idx_step;
  logic [IW-1:0]      hi_next;
  logic               in_range;
  logic [AW-1:0]      idx_addr;

  logic [VALUE_W-1:0] add_a, add_b, add_sum;
  logic               add_sub;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic [VALUE_W-1:0] mem_rdata;

  logic [POS_W-1:0]    in_low, in_high, in_qpos;
  logic [AMOUNT_W-1:0] in_amount;

  assign in_low    = s_axis_tdata[LOW_LSB +: POS_W];
  assign in_high   = s_axis_tdata[HIGH_LSB +: POS_W];
  assign in_amount = s_axis_tdata[AMT_LSB +: AMOUNT_W];
  assign in_qpos   = s_axis_tdata[QPOS_LSB +: POS_W];

  // Walks are bounded by the configured size, capped at the tree capacity.
  assign size_ext = IW'(size_q);
  assign n_eff    = (size_ext > MAX_IDX) ? MAX_IDX : size_ext;
  assign in_range = (idx_q != '0) && (idx_q <= n_eff);
  assign idx_addr = AW'(idx_q - IW'(1));
  assign hi_next  = hi_q + IW'(1);

  // Index step unit: updates climb by the lowest set bit, queries descend.
  assign low_bit  = idx_q & (~idx_q + IW'(1));
  assign idx_step = (state_q == ST_UP_WR) ? (idx_q + low_bit) : (idx_q - low_bit);

  // Shared 64-bit add/subtract unit. The second update of a range add
  // subtracts the amount through the carry-in.
  always_comb begin
    if (state_q == ST_UP_WR) begin
      add_a   = mem_rdata;
      add_b   = delta_q;
      add_sub = second_q;
    end else begin
      add_a   = acc_q;
      add_b   = mem_rdata;
      add_sub = 1'b0;
    end
    add_sum = add_a + (add_b ^ {VALUE_W{add_sub}}) + VALUE_W'(add_sub);
  end

  frpq_ram #(
    .DEPTH (MAX_POSITIONS),
    .WIDTH (VALUE_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (idx_addr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    idx_d         = idx_q;
    hi_d          = hi_q;
    second_d      = second_q;
    delta_d       = delta_q;
    acc_d         = acc_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    out_data_d    = out_data_q;
    mem_we        = 1'b0;
    mem_waddr     = idx_addr;
    mem_wdata     = add_sum;
    s_axis_tready = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (s_axis_tuser == REQ_QUERY) begin
            idx_d   = IW'(in_qpos);
            acc_d   = '0;
            state_d = ST_DN_CHK;
          end else begin
            idx_d    = IW'(in_low);
            hi_d     = IW'(in_high);
            delta_d  = VALUE_W'(signed'(in_amount));
            second_d = 1'b0;
            state_d  = ST_UP_CHK;
          end
        end
      end
      ST_UP_CHK: begin
        // The read of the current entry is issued in this cycle.
        if (in_range) begin
          state_d = ST_UP_WR;
        end else if (!second_q && (hi_next <= n_eff)) begin
          idx_d    = hi_next;
          second_d = 1'b1;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_UP_WR: begin
        mem_we  = 1'b1;
        idx_d   = idx_step;
        state_d = ST_UP_CHK;
      end
      ST_DN_CHK: begin
        if (idx_q == '0) begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_d = 1'b1;
            out_data_d  = acc_q;
            state_d     = ST_IDLE;
          end
        end else if (idx_q <= n_eff) begin
          state_d = ST_DN_ACC;
        end else begin
          idx_d = idx_step;
        end
      end
      ST_DN_ACC: begin
        acc_d   = add_sum;
        idx_d   = idx_step;
        state_d = ST_DN_CHK;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      size_q      <= SIZE_RESET;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        size_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    hi_q       <= hi_d;
    second_q   <= second_d;
    delta_q    <= delta_d;
    acc_q      <= acc_d;
    out_data_q <= out_data_d;
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `FRPQ_ASSERT_NEXT(a_add_no_result, clk_i, rst_ni,
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_ADD) && !m_axis_tvalid,
    !m_axis_tvalid, "range add produced a result word")
  `FRPQ_ASSERT_NOW(a_result_from_walk, clk_i, rst_ni, $rose(m_axis_tvalid),
    $past(state_q) == ST_DN_CHK, "result word raised outside the query walk")
  `FRPQ_ASSERT_NOW(a_access_in_range, clk_i, rst_ni,
    (state_q == ST_UP_WR) || (state_q == ST_DN_ACC),
    (idx_q != '0) && (idx_q <= n_eff), "tree access outside positions in use")

endmodule

FILE: src/frpq_ram.sv
// Single-port-write, single-port-read tree memory with registered read data.
module frpq_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
